/* design/vnsd_pkg.sv */
// Package for the video no-signal detector: widths, register indexes,
// the configuration record and the record passed between the pipeline stages.
// No dependencies.
`default_nettype none

package vnsd_pkg;

    // Fixed widths of the pixel components and the limit register.
    localparam int COLOR_BITS = 8;
    localparam int LIMIT_BITS = 16;

    // Coordinate and dark-frame counter widths.
    localparam int COORD_BITS = 12;
    localparam int COUNT_BITS = 16;

    // Width of the configuration write data: the widest register.
    localparam int CFG_DATA_BITS = (LIMIT_BITS > COORD_BITS) ? LIMIT_BITS : COORD_BITS;
    localparam int CFG_ADDR_BITS = 3;

    // Width in which the counter and the limit are compared.
    localparam int CMP_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

    localparam logic [LIMIT_BITS-1:0] FRAME_LIMIT_RESET = LIMIT_BITS'(40);

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_THRESH_RED   = 3'd0,
        REG_THRESH_GREEN = 3'd1,
        REG_THRESH_BLUE  = 3'd2,
        REG_FRAME_LIMIT  = 3'd3,
        REG_WIN_X_START  = 3'd4,
        REG_WIN_Y_START  = 3'd5,
        REG_WIN_X_END    = 3'd6,
        REG_WIN_Y_END    = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [COLOR_BITS-1:0] thresh_red;
        logic [COLOR_BITS-1:0] thresh_green;
        logic [COLOR_BITS-1:0] thresh_blue;
        logic [LIMIT_BITS-1:0] frame_limit;
        logic [COORD_BITS-1:0] win_x_start;
        logic [COORD_BITS-1:0] win_y_start;
        logic [COORD_BITS-1:0] win_x_end;
        logic [COORD_BITS-1:0] win_y_end;
    } cfg_t;

    // One classified pixel leaving the input stage.
    typedef struct packed {
        logic fire;    // the staged pixel moves on this cycle
        logic bright;  // inside the window and above a threshold
        logic last;    // last pixel of its frame
    } pix_stage_t;

endpackage

`default_nettype wire

/* design/vnsd_intf.sv */
// Stream interfaces of the video no-signal detector: pixel beats in,
// per-frame result beats out. Depends on vnsd_pkg.
`default_nettype none

interface vnsd_pix_if;
    logic                            valid;
    logic                            ready;
    logic [vnsd_pkg::COLOR_BITS-1:0] pix_red;
    logic [vnsd_pkg::COLOR_BITS-1:0] pix_green;
    logic [vnsd_pkg::COLOR_BITS-1:0] pix_blue;
    logic [vnsd_pkg::COORD_BITS-1:0] col;
    logic [vnsd_pkg::COORD_BITS-1:0] row;
    logic                            frame_end;

    modport source (output valid, pix_red, pix_green, pix_blue, col, row, frame_end,
                    input ready);
    modport sink (input valid, pix_red, pix_green, pix_blue, col, row, frame_end,
                  output ready);
endinterface

interface vnsd_res_if;
    logic valid;
    logic ready;
    logic frame_usable;
    logic signal_present;

    modport source (output valid, frame_usable, signal_present, input ready);
    modport sink (input valid, frame_usable, signal_present, output ready);
endinterface

`default_nettype wire

/* design/vnsd_cfg_regs.sv */
// Configuration register file of the video no-signal detector.
// Depends on vnsd_pkg.
`default_nettype none

module vnsd_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [vnsd_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [vnsd_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output vnsd_pkg::cfg_t                          cfg
);

    vnsd_pkg::cfg_t cfg_reg;
    vnsd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (vnsd_pkg::cfg_index_t'(cfg_addr))
                vnsd_pkg::REG_THRESH_RED:
                    cfg_next.thresh_red = cfg_data[vnsd_pkg::COLOR_BITS-1:0];
                vnsd_pkg::REG_THRESH_GREEN:
                    cfg_next.thresh_green = cfg_data[vnsd_pkg::COLOR_BITS-1:0];
                vnsd_pkg::REG_THRESH_BLUE:
                    cfg_next.thresh_blue = cfg_data[vnsd_pkg::COLOR_BITS-1:0];
                vnsd_pkg::REG_FRAME_LIMIT:
                    cfg_next.frame_limit = cfg_data[vnsd_pkg::LIMIT_BITS-1:0];
                vnsd_pkg::REG_WIN_X_START:
                    cfg_next.win_x_start = cfg_data[vnsd_pkg::COORD_BITS-1:0];
                vnsd_pkg::REG_WIN_Y_START:
                    cfg_next.win_y_start = cfg_data[vnsd_pkg::COORD_BITS-1:0];
                vnsd_pkg::REG_WIN_X_END:
                    cfg_next.win_x_end = cfg_data[vnsd_pkg::COORD_BITS-1:0];
                vnsd_pkg::REG_WIN_Y_END:
                    cfg_next.win_y_end = cfg_data[vnsd_pkg::COORD_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg              <= '0;
            cfg_reg.frame_limit  <= vnsd_pkg::FRAME_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* design/vnsd_pixel_check.sv */
// Input stage: registers each pixel beat as a bright/last flag pair after
// the window and threshold tests. Depends on vnsd_pkg and vnsd_intf.
`default_nettype none

module vnsd_pixel_check (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire vnsd_pkg::cfg_t cfg,
    vnsd_pix_if.sink          pix,
    input  wire logic         out_free,
    output vnsd_pkg::pix_stage_t stage
);

    logic valid_reg;
    logic valid_next;
    logic bright_reg;
    logic last_reg;
    logic in_window;
    logic dark;
    logic fire;
    logic take;

    // The window test; an empty window (start not below end) matches nothing.
    assign in_window = (pix.col >= cfg.win_x_start) && (pix.col < cfg.win_x_end) &&
                       (pix.row >= cfg.win_y_start) && (pix.row < cfg.win_y_end);
    assign dark   = (pix.pix_red <= cfg.thresh_red) &&
                    (pix.pix_green <= cfg.thresh_green) &&
                    (pix.pix_blue <= cfg.thresh_blue);

    // Only a frame-end pixel waits for room in the result register.
    assign fire      = valid_reg && (!last_reg || out_free);
    assign pix.ready = !valid_reg || fire;
    assign take      = pix.valid && pix.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (fire)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            bright_reg <= in_window && !dark;
            last_reg   <= pix.frame_end;
        end
    end

    assign stage.fire   = fire;
    assign stage.bright = bright_reg;
    assign stage.last   = last_reg;

endmodule

`default_nettype wire

/* design/vnsd_frame_judge.sv */
// Frame stage: tracks whether the current frame stayed dark, counts dark
// frames, keeps the signal flag and holds the result register.
// Depends on vnsd_pkg and vnsd_intf.
`default_nettype none

module vnsd_frame_judge (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire vnsd_pkg::cfg_t       cfg,
    input  wire vnsd_pkg::pix_stage_t stage,
    output logic                      out_free,
    vnsd_res_if.source                res
);

    localparam logic [vnsd_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                              all_dark_reg;
    logic                              all_dark_next;
    logic [vnsd_pkg::COUNT_BITS-1:0]   count_reg;
    logic [vnsd_pkg::COUNT_BITS-1:0]   count_next;
    logic                              lost_reg;
    logic                              lost_next;
    logic                              res_valid_reg;
    logic                              res_valid_next;
    logic                              usable_reg;
    logic                              present_reg;

    logic                              frame_dark;
    logic                              judge;
    logic                              lost_kept;
    logic                              usable;
    logic [vnsd_pkg::CMP_BITS-1:0]     limit;
    logic [vnsd_pkg::CMP_BITS-1:0]     count_old_w;
    logic [vnsd_pkg::CMP_BITS-1:0]     count_new_w;

    assign out_free   = !res_valid_reg || res.ready;
    assign judge      = stage.fire && stage.last;
    assign frame_dark = all_dark_reg && !stage.bright;

    // A limit of zero behaves as one.
    assign limit = (cfg.frame_limit == '0) ? vnsd_pkg::CMP_BITS'(1)
                                            : vnsd_pkg::CMP_BITS'(cfg.frame_limit);
    assign count_old_w = vnsd_pkg::CMP_BITS'(count_reg);

    always_comb
    begin
        lost_kept = lost_reg;
        if (frame_dark)
        begin
            count_next = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;
        end
        else
        begin
            count_next = '0;
            if (count_old_w >= limit)
                lost_kept = 1'b0;
        end
    end

    assign count_new_w = vnsd_pkg::CMP_BITS'(count_next);
    assign usable      = count_new_w < limit;
    assign lost_next   = (count_new_w == limit) ? 1'b1 : lost_kept;

    always_comb
    begin
        all_dark_next = all_dark_reg;
        if (judge)
            all_dark_next = 1'b1;
        else if (stage.fire && stage.bright)
            all_dark_next = 1'b0;
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (judge)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_dark_reg  <= 1'b1;
            count_reg     <= '0;
            lost_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            all_dark_reg  <= all_dark_next;
            res_valid_reg <= res_valid_next;
            if (judge)
            begin
                count_reg <= count_next;
                lost_reg  <= lost_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (judge)
        begin
            usable_reg  <= usable;
            present_reg <= !lost_next;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.frame_usable   = usable_reg;
    assign res.signal_present = present_reg;

endmodule

`default_nettype wire

/* design/video_no_signal_detector_top.sv */
// Top level of the video no-signal detector.
// Depends on vnsd_pkg, vnsd_intf, vnsd_cfg_regs, vnsd_pixel_check, vnsd_frame_judge.
//
// Channel | Direction | Beat contents
// --------+-----------+---------------------------------------------------------
// pix     | in        | pix_red, pix_green, pix_blue, col, row, frame_end
// res     | out       | frame_usable, signal_present (one beat per frame)
// cfg     | in        | cfg_we, cfg_addr, cfg_data (plain register writes)
//
// The block takes one pixel beat every clock cycle while no frame-end pixel
// waits. Each pixel is tested against the window and the thresholds on its
// way into the input register; the frame judgement runs between that
// register and the result register, which registers each frame result.
// Only a frame-end pixel waits on a result that has not yet been taken; any
// other pixel moves on regardless, so a stalled result channel holds back the
// pixel stream only when a second frame end arrives behind it.
// Reset is asynchronous and active low; it clears the counter and the signal
// flag, marks the current frame as dark and loads the register defaults.
`default_nettype none

module video_no_signal_detector_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [vnsd_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [vnsd_pkg::CFG_DATA_BITS-1:0] cfg_data,
    vnsd_pix_if.sink                                pix,
    vnsd_res_if.source                              res
);

    vnsd_pkg::cfg_t       cfg;
    vnsd_pkg::pix_stage_t stage;
    logic                 out_free;

    // Register file; the user must write it only while the stream is idle, the block does not enforce this.
    vnsd_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    // Window and threshold test, registered per pixel.
    vnsd_pixel_check u_pixel_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .pix      (pix),
        .out_free (out_free),
        .stage    (stage)
    );

    // Dark-frame counting and the result register.
    vnsd_frame_judge u_frame_judge (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .stage    (stage),
        .out_free (out_free),
        .res      (res)
    );

endmodule

`default_nettype wire
